// ===== rtl/core/alj_pkg.sv =====
package alj_pkg;

   localparam int FracBitsDefault = 16;
   localparam int QueueDepth = 2;

   localparam logic [1:0] ModeNone = 2'd0;
   localparam logic [1:0] ModeInv  = 2'd1;
   localparam logic [1:0] ModeLog  = 2'd2;
   localparam logic [1:0] ModeRsvd = 2'd3;

   localparam logic [1:0] StatusOk   = 2'd0;
   localparam logic [1:0] StatusSkip = 2'd1;
   localparam logic [1:0] StatusNoAnc = 2'd2;
   localparam logic [1:0] StatusBad  = 2'd3;

   localparam logic [2:0] RegRic0001 = 3'd0;
   localparam logic [2:0] RegRic0210 = 3'd1;
   localparam logic [2:0] RegRic1112 = 3'd2;
   localparam logic [2:0] RegRic2021 = 3'd3;
   localparam logic [2:0] RegRic22Ox = 3'd4;
   localparam logic [2:0] RegOffYz   = 3'd5;
   localparam logic [2:0] RegMinDep  = 3'd6;
   localparam logic [2:0] RegSpare   = 3'd7;

   typedef struct packed {
      logic signed [31:0] landmark_x;
      logic signed [31:0] landmark_y;
      logic signed [31:0] landmark_z;
      logic signed [31:0] anchor_px;
      logic signed [31:0] anchor_py;
      logic signed [31:0] anchor_pz;
      logic [63:0]        anchor_quat_wx;
      logic [63:0]        anchor_quat_yz;
      logic [1:0]         mode;
      logic               anchor_present;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      req_type    item;
      logic [1:0] early_status;
   } task_type;

   typedef struct packed {
      logic signed [31:0] v;
      logic               ovf;
   } sat_type;

   function automatic sat_type sat34(input logic signed [33:0] s);
      sat_type r;
      r.ovf = 1'b0;
      r.v = s[31:0];
      if (s > 34'sd2147483647) begin
         r.v = 32'sh7fffffff;
         r.ovf = 1'b1;
      end else if (s < -34'sd2147483648) begin
         r.v = 32'sh80000000;
         r.ovf = 1'b1;
      end
      return r;
   endfunction

   function automatic sat_type fadd(input logic signed [31:0] a, input logic signed [31:0] b);
      return sat34(34'(a) + 34'(b));
   endfunction

   function automatic sat_type fsub(input logic signed [31:0] a, input logic signed [31:0] b);
      return sat34(34'(a) - 34'(b));
   endfunction

endpackage

// ===== rtl/core/alj_front.sv =====
module alj_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  alj_pkg::req_type  req_data,
   output logic              task_valid,
   input  logic              task_take,
   output alj_pkg::task_type task_data
);
   import alj_pkg::*;

   task_type   q_ff [QueueDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;
   task_type   t;

   always_comb begin
      t.item = req_data;
      if (req_data.mode == ModeNone || req_data.mode == ModeRsvd) t.early_status = StatusSkip;
      else if (!req_data.anchor_present) t.early_status = StatusNoAnc;
      else t.early_status = StatusOk;
   end

   assign req_stall  = (cnt_ff == 2'(QueueDepth));
   assign push       = req_valid && !req_stall;
   assign task_valid = (cnt_ff != 2'd0);
   assign pop        = task_valid && task_take;
   assign task_data  = q_ff[rd_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign rd_in  = rd_ff ^ pop;
   assign wr_in  = wr_ff ^ push;

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= t;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end
endmodule

// ===== rtl/core/alj_back.sv =====
module alj_back #(
   parameter int FRAC_BITS = alj_pkg::FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [6:0][63:0]   cfg,
   input  logic               task_valid,
   output logic               task_take,
   input  alj_pkg::task_type  task_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output alj_pkg::rsp_type   rsp_data
);
   import alj_pkg::*;

   // one shared multiplier; sequencer walks a micro-op list
   task_type   cur_ff;
   logic signed [31:0] r_ff [9];
   logic signed [31:0] ric [9];
   logic signed [31:0] a_ff [9];
   logic signed [31:0] j_ff [9];
   logic signed [31:0] m_ff [9];
   logic signed [31:0] q_ff [9];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] v_ff [3];
   logic signed [31:0] pc_ff [3];
   logic signed [31:0] acc_ff;
   logic               ovf_ff;
   logic [1:0]         k_ff;
   logic [3:0]         e_ff;
   logic               out_v_ff;
   rsp_type            out_ff;

   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   logic signed [64:0] prnd;
   sat_type            pm, sa;
   logic signed [31:0] tq [3];
   logic signed [31:0] qw, qx, qy, qz;

   function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
      return ({2'b00, row} << 1) + {2'b00, row} + {2'b00, col};
   endfunction

   function automatic logic [1:0] row_of(input logic [3:0] e);
      if (e < 4'd3) return 2'd0;
      else if (e < 4'd6) return 2'd1;
      return 2'd2;
   endfunction

   function automatic logic [1:0] col_of(input logic [3:0] e);
      logic [3:0] c;
      c = e - idx3(row_of(e), 2'd0);
      return c[1:0];
   endfunction

   assign ric[0] = cfg[0][63:32]; assign ric[1] = cfg[0][31:0];
   assign ric[2] = cfg[1][63:32]; assign ric[3] = cfg[1][31:0];
   assign ric[4] = cfg[2][63:32]; assign ric[5] = cfg[2][31:0];
   assign ric[6] = cfg[3][63:32]; assign ric[7] = cfg[3][31:0];
   assign ric[8] = cfg[4][63:32];
   assign tq[0] = cfg[4][31:0]; assign tq[1] = cfg[5][63:32]; assign tq[2] = cfg[5][31:0];
   assign qw = cur_ff.item.anchor_quat_wx[63:32];
   assign qx = cur_ff.item.anchor_quat_wx[31:0];
   assign qy = cur_ff.item.anchor_quat_yz[63:32];
   assign qz = cur_ff.item.anchor_quat_yz[31:0];

   localparam logic [2:0] PhIdle = 3'd0, PhQ = 3'd1, PhV = 3'd2, PhPc = 3'd3,
                          PhJ = 3'd4, PhA = 3'd5, PhM = 3'd6, PhOut = 3'd7;
   logic [2:0] ph_ff;

   // operand select: e_ff is the output element, k_ff the dot term
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (ph_ff)
         PhQ: begin
            unique case (e_ff)
               4'd0: begin ma = qx; mb = qx; end
               4'd1: begin ma = qy; mb = qy; end
               4'd2: begin ma = qz; mb = qz; end
               4'd3: begin ma = qx; mb = qy; end
               4'd4: begin ma = qx; mb = qz; end
               4'd5: begin ma = qy; mb = qz; end
               4'd6: begin ma = qw; mb = qx; end
               4'd7: begin ma = qw; mb = qy; end
               default: begin ma = qw; mb = qz; end
            endcase
         end
         PhV: begin ma = r_ff[idx3(k_ff, e_ff[1:0])]; mb = d_ff[k_ff]; end
         PhPc: begin ma = ric[idx3(k_ff, e_ff[1:0])]; mb = v_ff[k_ff]; end
         PhJ: begin ma = pc_ff[e_ff[1:0]]; mb = pc_ff[2]; end
         PhA: begin
            ma = r_ff[idx3(row_of(e_ff), k_ff)];
            mb = ric[idx3(k_ff, col_of(e_ff))];
         end
         PhM: begin
            ma = a_ff[idx3(row_of(e_ff), k_ff)];
            mb = j_ff[idx3(k_ff, col_of(e_ff))];
         end
         default: ;
      endcase
   end

   assign prod = ma * mb;
   assign prnd = 65'(prod) + (65'sd1 <<< (FRAC_BITS - 1));
   always_comb begin
      logic signed [64:0] sh;
      sh = prnd >>> FRAC_BITS;
      pm.ovf = 1'b0;
      pm.v = sh[31:0];
      if (sh > 65'sd2147483647) begin pm.v = 32'sh7fffffff; pm.ovf = 1'b1; end
      else if (sh < -65'sd2147483648) begin pm.v = 32'sh80000000; pm.ovf = 1'b1; end
   end
   assign sa = fadd((k_ff == 2'd0) ? 32'sd0 : acc_ff, pm.v);

   logic busy_ff;
   assign task_take = !busy_ff && (!out_v_ff || !rsp_stall);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   logic signed [31:0] one;
   assign one = 32'sd1 <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      logic    o;
      logic    ov;
      rsp_type er;
      sat_type s0, s1, s2, s3, s4;
      if (reset) begin
         busy_ff <= 1'b0;
         out_v_ff <= 1'b0;
         ph_ff <= PhIdle;
      end else begin
         ov = out_v_ff && rsp_stall;
         if (task_valid && task_take) begin
            cur_ff <= task_data;
            if (task_data.early_status != StatusOk) begin
               er = '0;
               er.status = task_data.early_status;
               out_ff <= er;
               ov = 1'b1;
            end else begin
               busy_ff <= 1'b1;
               ph_ff <= PhQ;
               e_ff <= '0;
               k_ff <= '0;
               s0 = fsub(task_data.item.landmark_x, task_data.item.anchor_px);
               s1 = fsub(task_data.item.landmark_y, task_data.item.anchor_py);
               s2 = fsub(task_data.item.landmark_z, task_data.item.anchor_pz);
               d_ff[0] <= s0.v; d_ff[1] <= s1.v; d_ff[2] <= s2.v;
               ovf_ff <= s0.ovf | s1.ovf | s2.ovf;
            end
         end else if (busy_ff) begin
            o = ovf_ff;
            unique case (ph_ff)
               PhQ: begin
                  q_ff[e_ff] <= pm.v;
                  o |= pm.ovf;
                  if (e_ff == 4'd8) begin
                     ph_ff <= PhV;
                     e_ff <= '0;
                  end else e_ff <= e_ff + 4'd1;
                  if (e_ff == 4'd8) begin
                     // rotation from products (wz is pm this cycle)
                     s0 = fadd(q_ff[1], q_ff[2]); s1 = fadd(s0.v, s0.v);
                     s2 = fsub(one, s1.v); r_ff[0] <= s2.v; o |= s0.ovf|s1.ovf|s2.ovf;
                     s0 = fsub(q_ff[3], pm.v); s1 = fadd(s0.v, s0.v);
                     r_ff[1] <= s1.v; o |= s0.ovf|s1.ovf;
                     s0 = fadd(q_ff[4], q_ff[7]); s1 = fadd(s0.v, s0.v);
                     r_ff[2] <= s1.v; o |= s0.ovf|s1.ovf;
                     s0 = fadd(q_ff[3], pm.v); s1 = fadd(s0.v, s0.v);
                     r_ff[3] <= s1.v; o |= s0.ovf|s1.ovf;
                     s0 = fadd(q_ff[0], q_ff[2]); s1 = fadd(s0.v, s0.v);
                     s2 = fsub(one, s1.v); r_ff[4] <= s2.v; o |= s0.ovf|s1.ovf|s2.ovf;
                     s0 = fsub(q_ff[5], q_ff[6]); s1 = fadd(s0.v, s0.v);
                     r_ff[5] <= s1.v; o |= s0.ovf|s1.ovf;
                     s0 = fsub(q_ff[4], q_ff[7]); s1 = fadd(s0.v, s0.v);
                     r_ff[6] <= s1.v; o |= s0.ovf|s1.ovf;
                     s0 = fadd(q_ff[5], q_ff[6]); s1 = fadd(s0.v, s0.v);
                     r_ff[7] <= s1.v; o |= s0.ovf|s1.ovf;
                     s0 = fadd(q_ff[0], q_ff[1]); s1 = fadd(s0.v, s0.v);
                     s2 = fsub(one, s1.v); r_ff[8] <= s2.v; o |= s0.ovf|s1.ovf|s2.ovf;
                  end
               end
               PhV, PhPc, PhA, PhM: begin
                  o |= pm.ovf | sa.ovf;
                  acc_ff <= sa.v;
                  if (k_ff == 2'd2) begin
                     k_ff <= '0;
                     if (ph_ff == PhV) begin
                        s3 = fsub(sa.v, tq[e_ff[1:0]]);
                        v_ff[e_ff[1:0]] <= s3.v; o |= s3.ovf;
                     end else if (ph_ff == PhPc) pc_ff[e_ff[1:0]] <= sa.v;
                     else if (ph_ff == PhA) a_ff[e_ff] <= sa.v;
                     else m_ff[e_ff] <= sa.v;
                     if ((ph_ff == PhV || ph_ff == PhPc) && e_ff == 4'd2) begin
                        e_ff <= '0;
                        ph_ff <= (ph_ff == PhV) ? PhPc : PhJ;
                     end else if (e_ff == 4'd8) begin
                        e_ff <= '0;
                        ph_ff <= (ph_ff == PhA) ? PhM : PhOut;
                     end else e_ff <= e_ff + 4'd1;
                  end else k_ff <= k_ff + 2'd1;
               end
               PhJ: begin
                  if (e_ff == 4'd0 && (ovf_ff || pc_ff[2] <= $signed({1'b0, cfg[6][30:0]}))) begin
                     ph_ff <= PhOut;
                     o = 1'b1;
                  end else begin
                     if (cur_ff.item.mode == ModeInv) begin
                        s4 = fsub(32'sd0, pm.v);
                        o |= pm.ovf | s4.ovf;
                        j_ff[idx3(e_ff[1:0], 2'd2)] <= s4.v;
                     end else j_ff[idx3(e_ff[1:0], 2'd2)] <= pc_ff[e_ff[1:0]];
                     j_ff[0] <= pc_ff[2]; j_ff[1] <= '0;
                     j_ff[3] <= '0; j_ff[4] <= pc_ff[2];
                     j_ff[6] <= '0; j_ff[7] <= '0;
                     if (e_ff == 4'd2) begin e_ff <= '0; ph_ff <= PhA; end
                     else e_ff <= e_ff + 4'd1;
                  end
               end
               default: begin
                  busy_ff <= 1'b0;
                  ov = 1'b1;
                  out_ff.m00 <= o ? '0 : m_ff[0]; out_ff.m01 <= o ? '0 : m_ff[1];
                  out_ff.m02 <= o ? '0 : m_ff[2]; out_ff.m10 <= o ? '0 : m_ff[3];
                  out_ff.m11 <= o ? '0 : m_ff[4]; out_ff.m12 <= o ? '0 : m_ff[5];
                  out_ff.m20 <= o ? '0 : m_ff[6]; out_ff.m21 <= o ? '0 : m_ff[7];
                  out_ff.m22 <= o ? '0 : m_ff[8];
                  out_ff.status <= o ? StatusBad : StatusOk;
               end
            endcase
            ovf_ff <= o;
         end
         out_v_ff <= ov;
      end
   end
endmodule

// ===== rtl/core/anchored_landmark_jacobian.sv =====
// Anchored landmark Jacobian. Each request word gives a landmark, its anchor pose
// and a mode; one response word carries R_anchor*R_ic*J in Q16.16 and a status.
// Skip and no-anchor words bypass the datapath and are registered straight into the response.
// Anchored words run on one shared 32x32 multiplier and hold the back end while it
// loads the word, forms the quaternion products, runs the two point transforms,
// builds the Jacobian column, forms the two 3x3 products and emits the result.
// A depth reject ends after the transforms. A two-entry queue decouples intake.
// The user must write configuration only while idle; the block does not enforce this.
module anchored_landmark_jacobian #(
   parameter int FRAC_BITS = alj_pkg::FracBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  alj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output alj_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data
);
   import alj_pkg::*;

   logic [6:0][63:0] cfg_ff;
   logic             tv, tt;
   task_type         td;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[RegRic0001] <= 64'(1) << (32 + FRAC_BITS);
         cfg_ff[RegRic0210] <= '0;
         cfg_ff[RegRic1112] <= 64'(1) << (32 + FRAC_BITS);
         cfg_ff[RegRic2021] <= '0;
         cfg_ff[RegRic22Ox] <= 64'(1) << (32 + FRAC_BITS);
         cfg_ff[RegOffYz]   <= '0;
         cfg_ff[RegMinDep]  <= 64'(((64'(1) << FRAC_BITS) * 5 + 50) / 100);
      end else if (csr_valid) begin
         if (csr_index == RegMinDep) cfg_ff[RegMinDep] <= {33'd0, csr_data[30:0]};
         else if (csr_index != RegSpare) cfg_ff[csr_index] <= csr_data;
      end
   end

   alj_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .task_valid(tv), .task_take(tt), .task_data(td)
   );

   alj_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .task_valid(tv), .task_take(tt), .task_data(td),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== rtl/core/alj_checker.sv =====
module alj_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input alj_pkg::rsp_type rsp_data
);
   import alj_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != StatusOk |-> rsp_data.m00 == 0 && rsp_data.m22 == 0)
      else $error("nonzero matrix on bad status");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");
   a_open: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled after reset");
endmodule

bind anchored_landmark_jacobian alj_checker u_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
